FILE: rtl/cmc_pkg.sv
package cmc_pkg;

  // Number of magnetometer axes tracked; axes past the third see a zero reading.
  localparam int AXES = 3;
  // Axes that have result fields.
  localparam int NOUT = 3;

  localparam int DATA_W = 16;
  localparam int SUM_W  = DATA_W + $clog2(AXES);

  // Divide by AXES as a multiply by a floored reciprocal plus one correction.
  localparam int          DIV_SH    = SUM_W;
  localparam int          DIV_RW    = DIV_SH + 1;
  localparam int          DIV_PW    = SUM_W + DIV_RW;
  localparam logic [DIV_RW-1:0] DIV_RECIP = DIV_RW'((64'd1 << DIV_SH) / AXES);
  localparam logic [SUM_W-1:0]  AXES_W    = SUM_W'(AXES);

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENSOR_ENABLED = 2'd0,
    CFG_MIN_SPAN       = 2'd1,
    CFG_MIN_SAMPLES    = 2'd2,
    CFG_MAX_SAMPLES    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    FUNC_START  = 1'b0,
    FUNC_SAMPLE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_DONE     = 2'd1,
    ST_FAIL     = 2'd2
  } status_e;

  localparam logic              RST_SENSOR_ENABLED = 1'b1;
  localparam logic [DATA_W-1:0] RST_MIN_SPAN       = 16'd100;
  localparam logic [DATA_W-1:0] RST_MIN_SAMPLES    = 16'd50;
  localparam logic [DATA_W-1:0] RST_MAX_SAMPLES    = 16'd2000;
  localparam logic [DATA_W-1:0] GAIN_ONE           = 16'd1;
  localparam logic [DATA_W-1:0] TALLY_MAX          = 16'hFFFF;

  // Per-axis view after one sample.
  typedef struct packed {
    logic signed [DATA_W-1:0] low;
    logic signed [DATA_W-1:0] high;
    logic        [DATA_W-1:0] span;      // spread, zero taken as one
    logic                     too_short; // spread below the minimum span
    logic signed [DATA_W-1:0] mid;       // midpoint, truncated toward zero
  } axis_res_t;

  typedef struct packed {
    status_e                         status;
    logic [NOUT-1:0][DATA_W-1:0]     offset;
    logic [DATA_W-1:0]               numerator;
    logic [NOUT-1:0][DATA_W-1:0]     den;
  } out_payload_t;

endpackage

FILE: rtl/cmc_if.sv
interface cmc_in_if
  import cmc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [DATA_W-1:0] field_x;
  logic signed [DATA_W-1:0] field_y;
  logic signed [DATA_W-1:0] field_z;

  modport source (output valid, output func, output field_x, output field_y,
                  output field_z, input ready);
  modport sink   (input valid, input func, input field_x, input field_y,
                  input field_z, output ready);
endinterface

interface cmc_out_if
  import cmc_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] offset_x;
  logic signed [DATA_W-1:0] offset_y;
  logic signed [DATA_W-1:0] offset_z;
  logic [DATA_W-1:0]        gain_numerator;
  logic [DATA_W-1:0]        gain_den_x;
  logic [DATA_W-1:0]        gain_den_y;
  logic [DATA_W-1:0]        gain_den_z;

  modport source (output valid, output status, output offset_x, output offset_y,
                  output offset_z, output gain_numerator, output gain_den_x,
                  output gain_den_y, output gain_den_z, input ready);
  modport sink   (input valid, input status, input offset_x, input offset_y,
                  input offset_z, input gain_numerator, input gain_den_x,
                  input gain_den_y, input gain_den_z, output ready);
endinterface

interface cmc_cfg_if
  import cmc_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/cmc_axis.sv
module cmc_axis
  import cmc_pkg::*;
(
  input  logic                     bounds_valid_i,
  input  logic signed [DATA_W-1:0] field_i,
  input  logic signed [DATA_W-1:0] low_i,
  input  logic signed [DATA_W-1:0] high_i,
  input  logic        [DATA_W-1:0] min_span_i,
  output axis_res_t                res_o
);

  logic signed [DATA_W-1:0] low_new;
  logic signed [DATA_W-1:0] high_new;
  logic        [DATA_W:0]   diff;
  logic signed [DATA_W:0]   sum;
  logic signed [DATA_W:0]   sum_adj;
  logic signed [DATA_W:0]   half;

  always_comb begin
    if (!bounds_valid_i) begin
      low_new  = field_i;
      high_new = field_i;
    end else begin
      low_new  = (field_i < low_i)  ? field_i : low_i;
      high_new = (field_i > high_i) ? field_i : high_i;
    end

    // high >= low here, so the spread fits the unsigned field width
    diff    = {high_new[DATA_W-1], high_new} - {low_new[DATA_W-1], low_new};
    // round a negative odd sum toward zero before halving
    sum     = $signed({low_new[DATA_W-1], low_new}) + $signed({high_new[DATA_W-1], high_new});
    sum_adj = sum + $signed({{DATA_W{1'b0}}, sum[DATA_W] & sum[0]});
    half    = sum_adj >>> 1;

    res_o.low       = low_new;
    res_o.high      = high_new;
    res_o.too_short = diff[DATA_W-1:0] < min_span_i;
    res_o.span      = (diff[DATA_W-1:0] == '0) ? GAIN_ONE : diff[DATA_W-1:0];
    res_o.mid       = half[DATA_W-1:0];
  end

endmodule

FILE: rtl/cmc_div_axes.sv
module cmc_div_axes
  import cmc_pkg::*;
(
  input  logic [SUM_W-1:0]  sum_i,
  output logic [DATA_W-1:0] avg_o
);

  logic [DIV_PW-1:0] prod;
  logic [SUM_W-1:0]  q_est;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  q_fix;

  always_comb begin
    // estimate is exact or one low
    prod  = DIV_PW'(sum_i) * DIV_PW'(DIV_RECIP);
    q_est = prod[DIV_SH +: SUM_W];
    rem   = sum_i - SUM_W'(q_est * AXES_W);
    q_fix = (rem >= AXES_W) ? q_est + SUM_W'(1) : q_est;
    avg_o = q_fix[DATA_W-1:0];
  end

endmodule

FILE: rtl/compass_minmax_calibration_unit.sv
// Compass min/max calibration unit: hard-iron bias and soft-iron scale.
//
// Channels (valid/ready, an item moves when both are high):
//   cfg_i  register writes: index 0 sensor_enabled, 1 min_span,
//          2 min_samples, 3 max_samples. Always ready; write only when idle.
//   in_i   one item per command: func 0 starts a calibration, func 1 delivers
//          a three-axis sample in field_x/y/z.
//   out_o  one item per input item: status (0 in progress, 1 completed,
//          2 failed) plus the stored offsets, gain numerator and denominators.
// Path: an accepted item is held in the input register while the bounds,
//   spans, midpoints and average are worked out combinationally, and the result
//   lands in the output register once the output slot is free or being emptied.
// Throughput: one item per cycle unless out_o stalls. The calibration state is
//   updated in the same cycle the result is registered, so the next item sees it at once.
// Stall: while out_o holds an item not taken, the input register holds too;
//   in_i.ready drops only when both registers are full and out_o is stalled.
// Reset: registers return to their defaults (sensor enabled, span 100,
//   min 50, max 2000), calibration idle, bias 0, scales 1/1, no items held.
module compass_minmax_calibration_unit
  import cmc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  cmc_cfg_if.sink  cfg_i,
  cmc_in_if.sink   in_i,
  cmc_out_if.source out_o
);

  // Configuration registers
  logic              sensor_en_q;
  logic [DATA_W-1:0] min_span_q;
  logic [DATA_W-1:0] min_samples_q;
  logic [DATA_W-1:0] max_samples_q;

  // Input register
  logic                     in_valid_q;
  func_e                    func_q;
  logic signed [DATA_W-1:0] field_q [NOUT];

  // Calibration state
  logic                     calibrating_q, calibrating_d;
  logic                     bounds_valid_q, bounds_valid_d;
  logic [DATA_W-1:0]        tally_q, tally_d;
  logic signed [DATA_W-1:0] low_q [AXES];
  logic signed [DATA_W-1:0] low_d [AXES];
  logic signed [DATA_W-1:0] high_q [AXES];
  logic signed [DATA_W-1:0] high_d [AXES];
  logic signed [DATA_W-1:0] offset_q [AXES];
  logic signed [DATA_W-1:0] offset_d [AXES];
  logic [DATA_W-1:0]        den_q [AXES];
  logic [DATA_W-1:0]        den_d [AXES];
  logic [DATA_W-1:0]        num_q, num_d;

  // Output register
  logic         out_valid_q;
  out_payload_t out_q, out_d;

  logic advance;

  logic signed [DATA_W-1:0] axis_field [AXES];
  axis_res_t                axis_res [AXES];
  logic [SUM_W-1:0]         span_sum;
  logic                     spans_ok;
  logic [DATA_W-1:0]        avg;
  logic [DATA_W-1:0]        tally_inc;
  logic                     at_max;
  logic                     finish;
  status_e                  status;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_en_q   <= RST_SENSOR_ENABLED;
      min_span_q    <= RST_MIN_SPAN;
      min_samples_q <= RST_MIN_SAMPLES;
      max_samples_q <= RST_MAX_SAMPLES;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_SENSOR_ENABLED: sensor_en_q   <= cfg_i.data[0];
        CFG_MIN_SPAN:       min_span_q    <= cfg_i.data;
        CFG_MIN_SAMPLES:    min_samples_q <= cfg_i.data;
        CFG_MAX_SAMPLES:    max_samples_q <= cfg_i.data;
        default:            ;
      endcase
    end
  end

  // Move the held item forward when the output slot is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      func_q     <= func_e'(in_i.func);
      field_q[0] <= in_i.field_x;
      field_q[1] <= in_i.field_y;
      field_q[2] <= in_i.field_z;
    end
  end

  // Per-axis bounds, spread and midpoint; an axis past the third reads zero.
  for (genvar g = 0; g < AXES; g++) begin : g_axis
    if (g < NOUT) begin : g_real
      assign axis_field[g] = field_q[g];
    end else begin : g_zero
      assign axis_field[g] = '0;
    end

    cmc_axis u_axis (
      .bounds_valid_i (bounds_valid_q),
      .field_i        (axis_field[g]),
      .low_i          (low_q[g]),
      .high_i         (high_q[g]),
      .min_span_i     (min_span_q),
      .res_o          (axis_res[g])
    );
  end

  always_comb begin
    span_sum = '0;
    spans_ok = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      span_sum = span_sum + SUM_W'(axis_res[i].span);
      spans_ok = spans_ok && !axis_res[i].too_short;
    end
  end

  cmc_div_axes u_div (
    .sum_i (span_sum),
    .avg_o (avg)
  );

  // Saturating tally, then the limits it is checked against.
  assign tally_inc = (tally_q == TALLY_MAX) ? tally_q : tally_q + DATA_W'(1);
  assign at_max    = tally_inc >= max_samples_q;
  assign finish    = !at_max && (tally_inc >= min_samples_q) && spans_ok;

  always_comb begin
    calibrating_d  = calibrating_q;
    bounds_valid_d = bounds_valid_q;
    tally_d        = tally_q;
    num_d          = num_q;
    low_d          = low_q;
    high_d         = high_q;
    offset_d       = offset_q;
    den_d          = den_q;
    status         = ST_PROGRESS;

    if (func_q == FUNC_START) begin
      if (sensor_en_q && !calibrating_q) begin
        // clear bounds and tally, bias 0, scales 1/1
        calibrating_d  = 1'b1;
        bounds_valid_d = 1'b0;
        tally_d        = '0;
        num_d          = GAIN_ONE;
        for (int i = 0; i < AXES; i++) begin
          low_d[i]    = '0;
          high_d[i]   = '0;
          offset_d[i] = '0;
          den_d[i]    = GAIN_ONE;
        end
      end else begin
        status = ST_FAIL;
      end
    end else if (!calibrating_q) begin
      status = ST_FAIL;
    end else begin
      bounds_valid_d = 1'b1;
      tally_d        = tally_inc;
      for (int i = 0; i < AXES; i++) begin
        low_d[i]  = axis_res[i].low;
        high_d[i] = axis_res[i].high;
      end
      if (at_max) begin
        status = ST_FAIL;
      end else if (finish) begin
        status = ST_DONE;
        num_d  = avg;
        for (int i = 0; i < AXES; i++) begin
          offset_d[i] = axis_res[i].mid;
          den_d[i]    = axis_res[i].span;
        end
      end
    end
  end

  // Result shows the stored values after this item; missing axes read 0 and 1.
  always_comb begin
    out_d.status    = status;
    out_d.numerator = num_d;
    for (int i = 0; i < NOUT; i++) begin
      out_d.offset[i] = '0;
      out_d.den[i]    = GAIN_ONE;
    end
    for (int i = 0; i < AXES && i < NOUT; i++) begin
      out_d.offset[i] = offset_d[i];
      out_d.den[i]    = den_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calibrating_q  <= 1'b0;
      bounds_valid_q <= 1'b0;
      tally_q        <= '0;
      num_q          <= GAIN_ONE;
      for (int i = 0; i < AXES; i++) begin
        low_q[i]    <= '0;
        high_q[i]   <= '0;
        offset_q[i] <= '0;
        den_q[i]    <= GAIN_ONE;
      end
    end else if (advance) begin
      calibrating_q  <= calibrating_d;
      bounds_valid_q <= bounds_valid_d;
      tally_q        <= tally_d;
      num_q          <= num_d;
      low_q          <= low_d;
      high_q         <= high_d;
      offset_q       <= offset_d;
      den_q          <= den_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_q.status;
  assign out_o.offset_x       = out_q.offset[0];
  assign out_o.offset_y       = out_q.offset[1];
  assign out_o.offset_z       = out_q.offset[2];
  assign out_o.gain_numerator = out_q.numerator;
  assign out_o.gain_den_x     = out_q.den[0];
  assign out_o.gain_den_y     = out_q.den[1];
  assign out_o.gain_den_z     = out_q.den[2];

endmodule
